// File: rtl/core/rpe_pkg.sv
package rpe_pkg;

    // configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_REGS  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW2_LO = 3'd4,
        REG_ROW2_HI = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] ROW0_LO_RST = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW0_HI_RST = 64'h0;
    localparam logic [CFG_W-1:0] ROW1_LO_RST = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ROW1_HI_RST = 64'h0;
    localparam logic [CFG_W-1:0] ROW2_LO_RST = 64'h0;
    localparam logic [CFG_W-1:0] ROW2_HI_RST = 64'h0001_0000_0000_0000;

    // number formats
    localparam int ENTRY_W         = 32;   // one matrix entry, signed Q16.16
    localparam int FRAC_BITS       = 16;
    localparam int PROJ_BITS       = 40;   // projected magnitude saturates at 2^40
    localparam int DIST_W          = 32;
    localparam int SQ_W            = 2 * DIST_W;
    localparam int COORD_WIDTH_DEF = 32;

    // divider lanes: x and y share the depth as divisor
    localparam int LANES = 2;

endpackage

// File: rtl/core/rpe_in_if.sv
interface rpe_in_if
    import rpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] world_x;
    logic signed [COORD_WIDTH-1:0] world_y;
    logic signed [COORD_WIDTH-1:0] world_z;
    logic signed [COORD_WIDTH-1:0] seen_u;
    logic signed [COORD_WIDTH-1:0] seen_v;

    modport source (
        output valid, world_x, world_y, world_z, seen_u, seen_v,
        input  ready
    );
    modport sink (
        input  valid, world_x, world_y, world_z, seen_u, seen_v,
        output ready
    );
endinterface

// File: rtl/core/rpe_out_if.sv
interface rpe_out_if
    import rpe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] error_dist;
    logic              zero_depth;

    modport source (
        output valid, error_dist, zero_depth,
        input  ready
    );
    modport sink (
        input  valid, error_dist, zero_depth,
        output ready
    );
endinterface

// File: rtl/core/rpe_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor. Remainder must start below the divisor.
module rpe_div
    import rpe_pkg::*;
#(
    parameter int DEN_W  = 50,
    parameter int SIDE_W = 8
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DEN_W-1:0]     in_rem  [LANES],
    input  logic [PROJ_BITS-1:0] in_feed [LANES],
    input  logic [DEN_W-1:0]     in_den,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [PROJ_BITS-1:0] out_quo [LANES],
    output logic [SIDE_W-1:0]    out_side
);

    localparam int STAGES = PROJ_BITS;

    logic                 v_reg     [STAGES];
    logic [DEN_W-1:0]     rem_reg   [STAGES][LANES];
    logic [DEN_W-1:0]     rem_next  [STAGES][LANES];
    logic [PROJ_BITS-1:0] feed_reg  [STAGES][LANES];
    logic [PROJ_BITS-1:0] feed_next [STAGES][LANES];
    logic [PROJ_BITS-1:0] quo_reg   [STAGES][LANES];
    logic [PROJ_BITS-1:0] quo_next  [STAGES][LANES];
    logic [DEN_W-1:0]     den_reg   [STAGES];
    logic [SIDE_W-1:0]    side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 v_prev;
        logic [DEN_W-1:0]     rem_prev  [LANES];
        logic [PROJ_BITS-1:0] feed_prev [LANES];
        logic [PROJ_BITS-1:0] quo_prev  [LANES];
        logic [DEN_W-1:0]     den_prev;
        logic [SIDE_W-1:0]    side_prev;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign den_prev  = in_den;
            assign side_prev = in_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_prev[l]  = in_rem[l];
                assign feed_prev[l] = in_feed[l];
                assign quo_prev[l]  = '0;
            end
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_prev[l]  = rem_reg[k-1][l];
                assign feed_prev[l] = feed_reg[k-1][l];
                assign quo_prev[l]  = quo_reg[k-1][l];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_step
            logic [DEN_W:0] trial;
            logic           ge;
            assign trial = {rem_prev[l], feed_prev[l][PROJ_BITS-1]};
            assign ge    = trial >= {1'b0, den_prev};
            assign rem_next[k][l]  = ge ? DEN_W'(trial - {1'b0, den_prev})
                                        : trial[DEN_W-1:0];
            assign feed_next[k][l] = {feed_prev[l][PROJ_BITS-2:0], 1'b0};
            assign quo_next[k][l]  = {quo_prev[l][PROJ_BITS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next[k];
                feed_reg[k] <= feed_next[k];
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// File: rtl/core/rpe_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rpe_sqrt
    import rpe_pkg::*;
#(
    parameter int SIDE_W = 2
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DIST_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = DIST_W;
    localparam int REM_W  = DIST_W + 2;

    logic              v_reg     [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [REM_W-1:0]  rem_next  [STAGES];
    logic [DIST_W-1:0] root_reg  [STAGES];
    logic [DIST_W-1:0] root_next [STAGES];
    logic [SQ_W-1:0]   rad_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic              v_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [DIST_W-1:0] root_prev;
        logic [SQ_W-1:0]   rad_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign side_prev = in_side;
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // remainder stays below 2^32 before the last step, so the top bits drop safely
        assign cur          = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1:SQ_W-2]};
        assign trial        = {root_prev, 2'b01};
        assign ge           = cur >= trial;
        assign rem_next[k]  = ge ? cur - trial : cur;
        assign root_next[k] = {root_prev[DIST_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= {rad_prev[SQ_W-3:0], 2'b00};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// File: rtl/core/reprojection_error.sv
// Pinhole reprojection error. Each corr word carries a 3D point and the image
// point where it was observed; the point goes through the 3x4 matrix [R|t]
// held in six 64-bit config registers, x and y are divided by the depth, and
// the result word carries the Euclidean distance to the observed point, all
// in Q16.16. One word is accepted every clock while the skid is empty. A word
// passes transform and operand prep, the divider (one quotient bit per stage),
// difference/square/sum, the square root (one root bit per stage) and 1 output
// register. A one-word skid behind the output register
// absorbs a stall; corr.ready drops while the skid is full. A zero depth sets
// zero_depth and forces error_dist to all ones; distances of 2^32 raw or more
// saturate to all ones. Config writes must happen with the pipe empty.
module reprojection_error
    import rpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    rpe_in_if.sink               corr,
    rpe_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int PROD_W = ENTRY_W + COORD_WIDTH;      // exact product magnitude
    localparam int TERM_W = PROD_W - FRAC_BITS;         // after dropping fraction
    localparam int SUM_W  = COORD_WIDTH + 18;           // X, Y, Z
    localparam int SHR_W  = PROJ_BITS - FRAC_BITS;      // integer quotient bits
    localparam int U_W    = PROJ_BITS + 2;              // signed projection
    localparam int DX_W   = ((U_W > COORD_WIDTH) ? U_W : COORD_WIDTH) + 1;

    typedef struct packed {
        logic                          zero;
        logic [LANES-1:0]              ovf;
        logic [LANES-1:0]              neg;
        logic signed [COORD_WIDTH-1:0] su;
        logic signed [COORD_WIDTH-1:0] sv;
    } dside_t;

    typedef struct packed {
        logic zero;
        logic sat;
    } sside_t;

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] row_reg [CFG_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[REG_ROW0_LO] <= ROW0_LO_RST;
            row_reg[REG_ROW0_HI] <= ROW0_HI_RST;
            row_reg[REG_ROW1_LO] <= ROW1_LO_RST;
            row_reg[REG_ROW1_HI] <= ROW1_HI_RST;
            row_reg[REG_ROW2_LO] <= ROW2_LO_RST;
            row_reg[REG_ROW2_HI] <= ROW2_HI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_ROW0_LO: row_reg[REG_ROW0_LO] <= cfg_data;
                REG_ROW0_HI: row_reg[REG_ROW0_HI] <= cfg_data;
                REG_ROW1_LO: row_reg[REG_ROW1_LO] <= cfg_data;
                REG_ROW1_HI: row_reg[REG_ROW1_HI] <= cfg_data;
                REG_ROW2_LO: row_reg[REG_ROW2_LO] <= cfg_data;
                REG_ROW2_HI: row_reg[REG_ROW2_HI] <= cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    logic signed [ENTRY_W-1:0] mat  [3][3];
    logic signed [ENTRY_W-1:0] tvec [3];

    assign mat[0][0] = row_reg[REG_ROW0_LO][CFG_W-1:ENTRY_W];
    assign mat[0][1] = row_reg[REG_ROW0_LO][ENTRY_W-1:0];
    assign mat[0][2] = row_reg[REG_ROW0_HI][CFG_W-1:ENTRY_W];
    assign tvec[0]   = row_reg[REG_ROW0_HI][ENTRY_W-1:0];
    assign mat[1][0] = row_reg[REG_ROW1_LO][CFG_W-1:ENTRY_W];
    assign mat[1][1] = row_reg[REG_ROW1_LO][ENTRY_W-1:0];
    assign mat[1][2] = row_reg[REG_ROW1_HI][CFG_W-1:ENTRY_W];
    assign tvec[1]   = row_reg[REG_ROW1_HI][ENTRY_W-1:0];
    assign mat[2][0] = row_reg[REG_ROW2_LO][CFG_W-1:ENTRY_W];
    assign mat[2][1] = row_reg[REG_ROW2_LO][ENTRY_W-1:0];
    assign mat[2][2] = row_reg[REG_ROW2_HI][CFG_W-1:ENTRY_W];
    assign tvec[2]   = row_reg[REG_ROW2_HI][ENTRY_W-1:0];

    // ---------------------------------------------------------------
    // flow control: whole pipe moves unless the skid holds a word
    // ---------------------------------------------------------------
    logic en;
    logic s_v_reg;

    assign en         = !s_v_reg;
    assign corr.ready = en;

    // ---------------------------------------------------------------
    // stage A: nine magnitude products
    // ---------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] wvec [3];
    logic [PROD_W-1:0]             a_prod_next [3][3];
    logic                          a_neg_next  [3][3];
    logic                          a_v_reg;
    logic [PROD_W-1:0]             a_prod_reg  [3][3];
    logic                          a_neg_reg   [3][3];
    logic signed [COORD_WIDTH-1:0] a_su_reg;
    logic signed [COORD_WIDTH-1:0] a_sv_reg;

    assign wvec[0] = corr.world_x;
    assign wvec[1] = corr.world_y;
    assign wvec[2] = corr.world_z;

    always_comb
    begin
        logic [ENTRY_W-1:0]     mag_m;
        logic [COORD_WIDTH-1:0] mag_w;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag_m = mat[r][c][ENTRY_W-1] ? ENTRY_W'(-mat[r][c]) : ENTRY_W'(mat[r][c]);
                mag_w = wvec[c][COORD_WIDTH-1] ? COORD_WIDTH'(-wvec[c])
                                               : COORD_WIDTH'(wvec[c]);
                a_prod_next[r][c] = PROD_W'(mag_m) * PROD_W'(mag_w);
                a_neg_next[r][c]  = mat[r][c][ENTRY_W-1] ^ wvec[c][COORD_WIDTH-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= corr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            a_neg_reg  <= a_neg_next;
            a_su_reg   <= corr.seen_u;
            a_sv_reg   <= corr.seen_v;
        end
    end

    // ---------------------------------------------------------------
    // stage B: truncate each product toward zero, sum with t
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0]       b_xyz_next [3];
    logic                          b_v_reg;
    logic signed [SUM_W-1:0]       b_xyz_reg  [3];
    logic signed [COORD_WIDTH-1:0] b_su_reg;
    logic signed [COORD_WIDTH-1:0] b_sv_reg;

    always_comb
    begin
        logic [TERM_W-1:0]       term;
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = SUM_W'(tvec[r]);
            for (int c = 0; c < 3; c++)
            begin
                term = a_prod_reg[r][c][PROD_W-1:FRAC_BITS];
                acc  = a_neg_reg[r][c] ? acc - $signed(SUM_W'(term))
                                       : acc + $signed(SUM_W'(term));
            end
            b_xyz_next[r] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_xyz_reg <= b_xyz_next;
            b_su_reg  <= a_su_reg;
            b_sv_reg  <= a_sv_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage C: magnitudes, saturation test, divider operands
    // ---------------------------------------------------------------
    logic [SUM_W-1:0]     c_mag  [3];
    logic [SUM_W-1:0]     c_rem_next  [LANES];
    logic [PROJ_BITS-1:0] c_feed_next [LANES];
    dside_t               c_side_next;
    logic                 c_v_reg;
    logic [SUM_W-1:0]     c_rem_reg  [LANES];
    logic [PROJ_BITS-1:0] c_feed_reg [LANES];
    logic [SUM_W-1:0]     c_den_reg;
    dside_t               c_side_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            c_mag[r] = b_xyz_reg[r][SUM_W-1] ? SUM_W'(-b_xyz_reg[r]) : SUM_W'(b_xyz_reg[r]);
        end
        c_side_next.zero = (b_xyz_reg[2] == '0);
        c_side_next.su   = b_su_reg;
        c_side_next.sv   = b_sv_reg;
        for (int l = 0; l < LANES; l++)
        begin
            // integer part of the quotient reaching 2^24 means saturation
            c_rem_next[l]       = c_mag[l] >> SHR_W;
            c_side_next.ovf[l]  = (c_mag[l] >> SHR_W) >= c_mag[2];
            c_side_next.neg[l]  = b_xyz_reg[l][SUM_W-1] ^ b_xyz_reg[2][SUM_W-1];
            c_feed_next[l]      = {c_mag[l][SHR_W-1:0], FRAC_BITS'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_rem_reg  <= c_rem_next;
            c_feed_reg <= c_feed_next;
            c_den_reg  <= c_mag[2];
            c_side_reg <= c_side_next;
        end
    end

    // ---------------------------------------------------------------
    // divider: u = X*2^16/Z, v = Y*2^16/Z magnitudes
    // ---------------------------------------------------------------
    logic                 dv_valid;
    logic [PROJ_BITS-1:0] dv_quo [LANES];
    logic [$bits(dside_t)-1:0] dv_side_raw;
    dside_t               dv_side;

    rpe_div #(
        .DEN_W  (SUM_W),
        .SIDE_W ($bits(dside_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_rem    (c_rem_reg),
        .in_feed   (c_feed_reg),
        .in_den    (c_den_reg),
        .in_side   (c_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side_raw)
    );

    assign dv_side = dside_t'(dv_side_raw);

    // ---------------------------------------------------------------
    // stage D: signed projection minus observation, magnitude
    // ---------------------------------------------------------------
    logic [DIST_W-1:0] d_adx_next [LANES];
    logic [LANES-1:0]  d_big_next;
    logic              d_v_reg;
    logic [DIST_W-1:0] d_adx_reg  [LANES];
    logic [LANES-1:0]  d_big_reg;
    logic              d_zero_reg;

    always_comb
    begin
        logic [PROJ_BITS:0]     pmag;
        logic signed [U_W-1:0]  proj;
        logic signed [DX_W-1:0] seen;
        logic signed [DX_W-1:0] diff;
        logic [DX_W-1:0]        adiff;
        for (int l = 0; l < LANES; l++)
        begin
            pmag  = dv_side.ovf[l] ? {1'b1, PROJ_BITS'(0)} : {1'b0, dv_quo[l]};
            proj  = dv_side.neg[l] ? -$signed(U_W'(pmag)) : $signed(U_W'(pmag));
            seen  = (l == 0) ? DX_W'(dv_side.su) : DX_W'(dv_side.sv);
            diff  = DX_W'(proj) - seen;
            adiff = diff[DX_W-1] ? DX_W'(-diff) : DX_W'(diff);
            d_adx_next[l] = adiff[DIST_W-1:0];
            d_big_next[l] = |adiff[DX_W-1:DIST_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_adx_reg  <= d_adx_next;
            d_big_reg  <= d_big_next;
            d_zero_reg <= dv_side.zero;
        end
    end

    // ---------------------------------------------------------------
    // stage E: squares
    // ---------------------------------------------------------------
    logic            e_v_reg;
    logic [SQ_W-1:0] e_sq_reg [LANES];
    logic            e_sat_reg;
    logic            e_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                e_sq_reg[l] <= SQ_W'(d_adx_reg[l]) * SQ_W'(d_adx_reg[l]);
            end
            e_sat_reg  <= |d_big_reg;
            e_zero_reg <= d_zero_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage F: sum of squares, overflow past 64 bits saturates
    // ---------------------------------------------------------------
    logic [SQ_W:0]   f_sum;
    logic            f_v_reg;
    logic [SQ_W-1:0] f_rad_reg;
    sside_t          f_side_reg;

    assign f_sum = {1'b0, e_sq_reg[0]} + {1'b0, e_sq_reg[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_rad_reg       <= f_sum[SQ_W-1:0];
            f_side_reg.sat  <= e_sat_reg | f_sum[SQ_W];
            f_side_reg.zero <= e_zero_reg;
        end
    end

    // ---------------------------------------------------------------
    // square root
    // ---------------------------------------------------------------
    logic              sq_valid;
    logic [DIST_W-1:0] sq_root;
    logic [$bits(sside_t)-1:0] sq_side_raw;
    sside_t            sq_side;

    rpe_sqrt #(
        .SIDE_W ($bits(sside_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_v_reg),
        .in_rad    (f_rad_reg),
        .in_side   (f_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_raw)
    );

    assign sq_side = sside_t'(sq_side_raw);

    // ---------------------------------------------------------------
    // output register and skid
    // ---------------------------------------------------------------
    logic [DIST_W-1:0] l_dist;
    logic              o_v_reg;
    logic [DIST_W-1:0] o_dist_reg;
    logic              o_zd_reg;
    logic [DIST_W-1:0] s_dist_reg;
    logic              s_zd_reg;

    assign l_dist = (sq_side.zero || sq_side.sat) ? '1 : sq_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (!s_v_reg)
        begin
            if (!o_v_reg || result.ready)
            begin
                o_v_reg <= sq_valid;
            end
            else if (sq_valid)
            begin
                s_v_reg <= 1'b1;
            end
        end
        else if (result.ready)
        begin
            o_v_reg <= 1'b1;
            s_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s_v_reg)
        begin
            if (!o_v_reg || result.ready)
            begin
                o_dist_reg <= l_dist;
                o_zd_reg   <= sq_side.zero;
            end
            else
            begin
                s_dist_reg <= l_dist;
                s_zd_reg   <= sq_side.zero;
            end
        end
        else if (result.ready)
        begin
            o_dist_reg <= s_dist_reg;
            o_zd_reg   <= s_zd_reg;
        end
    end

    assign result.valid      = o_v_reg;
    assign result.error_dist = o_dist_reg;
    assign result.zero_depth = o_zd_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_v_reg |-> o_v_reg)
        else $error("skid holds a word while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_v_reg) |-> $past(o_v_reg && !result.ready && sq_valid))
        else $error("skid filled without a stalled output");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_v_reg && !result.ready) |=> s_v_reg)
        else $error("skid word lost during stall");

    a_zero_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_depth) |-> (result.error_dist == '1))
        else $error("zero depth without saturated distance");

endmodule
